>>> sv/ampersand_field_escape_codec_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ampersand field escape codec
// Concurrent checks clocked on clk and held off while rst is high.
// ----------------------------------------------------------------------------
`ifndef AMPERSAND_FIELD_ESCAPE_CODEC_ASSERT_SVH
`define AMPERSAND_FIELD_ESCAPE_CODEC_ASSERT_SVH

`ifndef SYNTHESIS

`define AFEC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define AFEC_ASSERT_IMPLIES(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`else

`define AFEC_ASSERT_ALWAYS(label, cond, msg)

`define AFEC_ASSERT_IMPLIES(label, pre, post, msg)

`endif

`endif

>>> sv/afec_pkg.sv
// ----------------------------------------------------------------------------
// afec_pkg
// Types and constants shared by the ampersand field escape codec modules.
// ----------------------------------------------------------------------------
package afec_pkg;

  localparam int MAX_RESULTS = 4;
  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);
  localparam int RIDX_W      = $clog2(MAX_RESULTS);

  localparam logic [3:0] CFG_BUFFER_LENGTH = 4'd0;
  localparam logic [3:0] CFG_TEXT_MODE     = 4'd1;

  localparam logic [15:0] BUFFER_LENGTH_RESET = 16'd1024;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_PCT  = 8'h25;
  localparam logic [7:0] CH_TWO  = 8'h32;
  localparam logic [7:0] CH_FIVE = 8'h35;
  localparam logic [7:0] CH_SIX  = 8'h36;

  typedef enum logic [1:0] {
    K_DATA = 2'd0,
    K_END  = 2'd1,
    K_ERR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NO_ROOM      = 3'd1,
    ST_MISSING_SEP  = 3'd2,
    ST_SPLIT_ESCAPE = 3'd3,
    ST_PAST_END     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,
    PH_IN    = 2'd1,
    PH_SEP   = 2'd2
  } phase_t;

  typedef struct packed {
    logic        func;
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        field_begin;
    logic [15:0] field_limit;
    logic        restart;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [15:0] addr;
    status_t     status;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [RCNT_W-1:0]        count;
    res_t [MAX_RESULTS-1:0]   ent;
  } qwr_t;

endpackage

>>> sv/afec_core.sv
// ----------------------------------------------------------------------------
// afec_core
// Input register, codec state and the single-pass encode and decode logic
// that turns one registered item into up to four results for the queue.
// ----------------------------------------------------------------------------
module afec_core import afec_pkg::*; #(
  parameter int POSITION_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic [3:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  item_t             in_item,
  input  logic [QLVL_W-1:0] q_level,
  output qwr_t              q_wr
);

  localparam int PW = POSITION_WIDTH;
  localparam int CW = ((PW > 16) ? PW : 16) + 2;

  logic          item_valid;
  item_t         item;
  logic [15:0]   buf_len;
  logic          text_on;

  logic [PW-1:0] position,    position_next;
  logic [PW-1:0] field_start, field_start_next;
  logic [15:0]   remaining,   remaining_next;
  phase_t        phase,       phase_next;
  logic [1:0]    hex_seen,    hex_seen_next;
  logic [3:0]    high_nib,    high_nib_next;
  logic          closed,      closed_next;
  logic          sticky,      sticky_next;

  logic                     fire;
  logic [CW-1:0]            len_x;
  res_t [MAX_RESULTS-1:0]   ent;
  logic [RCNT_W-1:0]        n;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
    else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
    return v;
  endfunction

  assign fire     = item_valid && (q_level <= QLVL_W'(QUEUE_DEPTH - MAX_RESULTS));
  assign in_ready = !item_valid || fire;
  assign len_x    = CW'(buf_len);

  always_comb begin
    logic done;
    logic fail;
    logic open;
    logic chk;
    position_next    = position;
    field_start_next = field_start;
    remaining_next   = remaining;
    phase_next       = phase;
    hex_seen_next    = hex_seen;
    high_nib_next    = high_nib;
    closed_next      = closed;
    sticky_next      = sticky;
    ent  = '0;
    n    = '0;
    done = 1'b0;
    fail = 1'b0;
    open = 1'b0;
    chk  = 1'b0;

    if (item.restart) begin
      position_next    = '0;
      field_start_next = '0;
      remaining_next   = '0;
      phase_next       = PH_FIRST;
      hex_seen_next    = '0;
      high_nib_next    = '0;
      closed_next      = 1'b0;
      sticky_next      = 1'b0;
    end

    if (item.func) begin
      if (sticky_next) done = 1'b1;
      if (!done && phase_next == PH_FIRST) begin
        remaining_next   = item.field_limit;
        field_start_next = position_next;
        hex_seen_next    = '0;
        phase_next       = PH_IN;
        if (remaining_next == 16'd0 || CW'(position_next) >= len_x) begin
          if (text_on) begin
            ent[n[RIDX_W-1:0]] = '{kind: K_DATA, data: 8'h00, addr: 16'(position_next),
                                   status: ST_OK, last: 1'b0};
            n = n + RCNT_W'(1);
          end
          ent[n[RIDX_W-1:0]] = '{kind: K_END, data: 8'h00, addr: 16'(position_next),
                                 status: ST_OK, last: 1'b0};
          n = n + RCNT_W'(1);
          phase_next = PH_SEP;
        end
      end
      if (!done && !item.byte_valid) done = 1'b1;
      if (!done && CW'(position_next) >= len_x) begin
        ent[n[RIDX_W-1:0]] = '{kind: K_ERR, data: 8'h00, addr: 16'(position_next),
                               status: ST_PAST_END, last: 1'b0};
        n = n + RCNT_W'(1);
        sticky_next = 1'b1;
        done = 1'b1;
      end
      if (!done && phase_next != PH_IN) begin
        done = 1'b1;
        if (item.data_byte == CH_AMP) begin
          position_next = position_next + PW'(1);
          open = 1'b1;
        end else begin
          ent[n[RIDX_W-1:0]] = '{kind: K_ERR, data: 8'h00, addr: 16'(position_next),
                                 status: ST_MISSING_SEP, last: 1'b0};
          n = n + RCNT_W'(1);
          sticky_next = 1'b1;
        end
      end
      if (!done && hex_seen_next == 2'd1) begin
        high_nib_next = hex_value(item.data_byte);
        hex_seen_next = 2'd2;
        position_next = position_next + PW'(1);
        done = 1'b1;
      end
      if (!done) begin
        if (hex_seen_next == 2'd2) begin
          ent[n[RIDX_W-1:0]] = '{kind: K_DATA, data: {high_nib_next, hex_value(item.data_byte)},
                                 addr: 16'(position_next), status: ST_OK, last: 1'b0};
          n = n + RCNT_W'(1);
          hex_seen_next  = '0;
          position_next  = position_next + PW'(1);
          remaining_next = remaining_next - 16'd1;
          chk = 1'b1;
        end else if (item.data_byte == CH_AMP) begin
          if (text_on) begin
            ent[n[RIDX_W-1:0]] = '{kind: K_DATA, data: 8'h00, addr: 16'(position_next),
                                   status: ST_OK, last: 1'b0};
            n = n + RCNT_W'(1);
          end
          ent[n[RIDX_W-1:0]] = '{kind: K_END, data: 8'h00, addr: 16'(position_next),
                                 status: ST_OK, last: 1'b0};
          n = n + RCNT_W'(1);
          position_next = position_next + PW'(1);
          open = 1'b1;
        end else if (item.data_byte == CH_PCT) begin
          if (CW'(position_next) + CW'(3) > len_x) begin
            ent[n[RIDX_W-1:0]] = '{kind: K_ERR, data: 8'h00, addr: 16'(position_next),
                                   status: ST_SPLIT_ESCAPE, last: 1'b0};
            n = n + RCNT_W'(1);
            sticky_next = 1'b1;
          end else begin
            hex_seen_next = 2'd1;
            position_next = position_next + PW'(1);
          end
        end else begin
          ent[n[RIDX_W-1:0]] = '{kind: K_DATA, data: item.data_byte,
                                 addr: 16'(position_next), status: ST_OK, last: 1'b0};
          n = n + RCNT_W'(1);
          position_next  = position_next + PW'(1);
          remaining_next = remaining_next - 16'd1;
          chk = 1'b1;
        end
      end
      if (open) begin
        remaining_next   = item.field_limit;
        field_start_next = position_next;
        hex_seen_next    = '0;
        phase_next       = PH_IN;
        chk = 1'b1;
      end
      if (chk && (remaining_next == 16'd0 || CW'(position_next) >= len_x)) begin
        if (text_on) begin
          ent[n[RIDX_W-1:0]] = '{kind: K_DATA, data: 8'h00, addr: 16'(position_next),
                                 status: ST_OK, last: 1'b0};
          n = n + RCNT_W'(1);
        end
        ent[n[RIDX_W-1:0]] = '{kind: K_END, data: 8'h00, addr: 16'(position_next),
                               status: ST_OK, last: 1'b0};
        n = n + RCNT_W'(1);
        phase_next = PH_SEP;
      end
    end else begin
      if (item.field_begin) begin
        field_start_next = position_next;
        remaining_next   = item.field_limit;
        closed_next      = 1'b0;
        if (position_next != '0) begin
          if (CW'(position_next) + CW'(1) < len_x) begin
            ent[n[RIDX_W-1:0]] = '{kind: K_DATA, data: CH_AMP, addr: 16'(position_next),
                                   status: ST_OK, last: 1'b0};
            n = n + RCNT_W'(1);
            position_next = position_next + PW'(1);
          end else begin
            fail = 1'b1;
          end
        end
      end
      if (!fail && item.byte_valid && !closed_next && remaining_next != 16'd0) begin
        if (text_on && item.data_byte == 8'h00) begin
          closed_next = 1'b1;
        end else if (item.data_byte == CH_AMP || item.data_byte == CH_PCT) begin
          if (CW'(position_next) + CW'(3) < len_x) begin
            ent[n[RIDX_W-1:0]] = '{kind: K_DATA, data: CH_PCT, addr: 16'(position_next),
                                   status: ST_OK, last: 1'b0};
            n = n + RCNT_W'(1);
            position_next = position_next + PW'(1);
            ent[n[RIDX_W-1:0]] = '{kind: K_DATA, data: CH_TWO, addr: 16'(position_next),
                                   status: ST_OK, last: 1'b0};
            n = n + RCNT_W'(1);
            position_next = position_next + PW'(1);
            ent[n[RIDX_W-1:0]] = '{kind: K_DATA,
                                   data: (item.data_byte == CH_AMP) ? CH_SIX : CH_FIVE,
                                   addr: 16'(position_next), status: ST_OK, last: 1'b0};
            n = n + RCNT_W'(1);
            position_next  = position_next + PW'(1);
            remaining_next = remaining_next - 16'd1;
          end else begin
            fail = 1'b1;
          end
        end else if (CW'(position_next) + CW'(1) < len_x) begin
          ent[n[RIDX_W-1:0]] = '{kind: K_DATA, data: item.data_byte,
                                 addr: 16'(position_next), status: ST_OK, last: 1'b0};
          n = n + RCNT_W'(1);
          position_next  = position_next + PW'(1);
          remaining_next = remaining_next - 16'd1;
        end else begin
          fail = 1'b1;
        end
      end
      if (fail) begin
        ent[n[RIDX_W-1:0]] = '{kind: K_ERR, data: 8'h00, addr: 16'(position_next),
                               status: ST_NO_ROOM, last: 1'b0};
        n = n + RCNT_W'(1);
        position_next = field_start_next;
        closed_next   = 1'b1;
      end
    end

    if (n != '0) ent[RIDX_W'(n - RCNT_W'(1))].last = 1'b1;
  end

  always_comb begin
    q_wr.ent   = ent;
    q_wr.count = fire ? n : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid  <= 1'b0;
      buf_len     <= BUFFER_LENGTH_RESET;
      text_on     <= 1'b1;
      position    <= '0;
      field_start <= '0;
      remaining   <= '0;
      phase       <= PH_FIRST;
      hex_seen    <= '0;
      high_nib    <= '0;
      closed      <= 1'b0;
      sticky      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_BUFFER_LENGTH: buf_len <= cfg_data;
          CFG_TEXT_MODE:     text_on <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_ready) begin
        item_valid <= in_valid;
        item       <= in_item;
      end
      if (fire) begin
        position    <= position_next;
        field_start <= field_start_next;
        remaining   <= remaining_next;
        phase       <= phase_next;
        hex_seen    <= hex_seen_next;
        high_nib    <= high_nib_next;
        closed      <= closed_next;
        sticky      <= sticky_next;
      end
    end
  end

endmodule

>>> sv/afec_result_queue.sv
// ----------------------------------------------------------------------------
// afec_result_queue
// Result register queue: takes up to four results in one cycle and hands
// them out one per transaction on the master side.
// ----------------------------------------------------------------------------
module afec_result_queue import afec_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  qwr_t              q_wr,
  output logic [QLVL_W-1:0] q_level,
  output logic              out_valid,
  input  logic              out_ready,
  output res_t              out_res
);

  res_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W-1:0] wr_ptr;
  logic              pop;

  assign out_valid = (q_level != '0);
  assign pop       = out_valid && out_ready;
  assign out_res   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr  <= '0;
      wr_ptr  <= '0;
      q_level <= '0;
    end else begin
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      wr_ptr  <= wr_ptr + QPTR_W'(q_wr.count);
      q_level <= q_level + QLVL_W'(q_wr.count) - QLVL_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (RCNT_W'(i) < q_wr.count) slots[wr_ptr + QPTR_W'(i)] <= q_wr.ent[i];
    end
  end

endmodule

>>> sv/ampersand_field_escape_codec.sv
// ----------------------------------------------------------------------------
// ampersand_field_escape_codec
// Packs fields into, or unpacks them from, an ampersand separated buffer
// with percent escapes for the ampersand and percent characters.
// ----------------------------------------------------------------------------
//  channel   role    contents
//  s_axis    input   one byte item per transaction, func in tuser
//  m_axis    output  one result per transaction, kind in tuser, last in tlast
//  cfg       write   register index and data, always ready
//
//  An item can be taken every cycle while the queue has room; its results go from the input
//  register into the result queue and leave one per cycle while m_axis_tready is high.
//  s_axis stalls only when the eight-entry result queue has fewer than four free slots.
//  Reset is synchronous and clears the state; buffer_length returns to 1024, text mode on.
// ----------------------------------------------------------------------------
module ampersand_field_escape_codec import afec_pkg::*; #(
  parameter int POSITION_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // data_byte[7:0], byte_valid[8], field_begin[9], field_limit[25:10], restart[26]
  input  logic [31:0] s_axis_tdata,
  // func[0]
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_byte[7:0], out_addr[23:8], status[26:24]
  output logic [31:0] m_axis_tdata,
  // out_kind[1:0]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  item_t             in_item;
  qwr_t              q_wr;
  logic [QLVL_W-1:0] q_level;
  res_t              out_res;

  assign in_item = '{func:        s_axis_tuser[0],
                     data_byte:   s_axis_tdata[7:0],
                     byte_valid:  s_axis_tdata[8],
                     field_begin: s_axis_tdata[9],
                     field_limit: s_axis_tdata[25:10],
                     restart:     s_axis_tdata[26]};

  assign cfg_ready = 1'b1;

  afec_core #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_item  (in_item),
    .q_level  (q_level),
    .q_wr     (q_wr)
  );

  afec_result_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .q_wr     (q_wr),
    .q_level  (q_level),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_res  (out_res)
  );

  assign m_axis_tdata = {5'b0, out_res.status, out_res.addr, out_res.data};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

`include "ampersand_field_escape_codec_assert.svh"

  `AFEC_ASSERT_IMPLIES(a_room_on_write, q_wr.count != '0, q_level <= QLVL_W'(QUEUE_DEPTH - MAX_RESULTS), "result queue written without room for a full item")
  `AFEC_ASSERT_ALWAYS(a_level_bound, q_level <= QLVL_W'(QUEUE_DEPTH), "result queue level beyond its depth")
  `AFEC_ASSERT_IMPLIES(a_last_on_final, q_wr.count != '0, q_wr.ent[RIDX_W'(q_wr.count - RCNT_W'(1))].last, "final result of an item written without last")

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for ampersand_field_escape_codec
// Directed and random encode and decode byte streams are driven through the
// input stream. A behavioural model of the codec predicts every result, and
// each output transaction is compared with it field by field. Both sides idle
// at random, and one long output hold-off fills the result queue.
// ----------------------------------------------------------------------------
module tb;
  import afec_pkg::*;

  localparam int   IDLE_LIMIT    = 1000;
  localparam int   SETTLE_CYCLES = 10;
  localparam logic FUNC_ENCODE   = 1'b0;
  localparam logic FUNC_DECODE   = 1'b1;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_pattern_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic [0:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index     = '0;
  logic [15:0] cfg_data      = '0;

  // Model of the codec: configuration and state
  logic [15:0] buf_len;
  logic        text_on;
  logic [15:0] buf_pos;
  logic [15:0] field_start;
  logic [15:0] remaining;
  phase_t      dec_phase;
  logic [1:0]  hex_count;
  logic [3:0]  hex_high;
  logic        field_shut;
  logic        stuck;

  res_t        step_out[$];
  res_t        result_fifo[$];

  int          error_count  = 0;
  int          idle_cycles  = 0;
  int          burst_left   = 0;
  int          items_sent   = 0;
  int          hold_request = 0;
  int          hold_left    = 0;
  int          mode_left    = 0;
  rx_pattern_t rx_mode      = RX_OPEN;

  ampersand_field_escape_codec DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // --------------------------------------------------------------------------
  // Codec model
  // --------------------------------------------------------------------------
  function automatic logic [3:0] hex_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return 4'(c - "0");
    if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
    if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
    return 4'd0;
  endfunction

  function automatic void clear_codec();
    buf_pos     = '0;
    field_start = '0;
    remaining   = '0;
    dec_phase   = PH_FIRST;
    hex_count   = '0;
    hex_high    = '0;
    field_shut  = 1'b0;
    stuck       = 1'b0;
  endfunction

  function automatic void note_result(kind_t k, logic [7:0] b, logic [15:0] a, status_t s);
    res_t r;
    r.kind   = k;
    r.data   = b;
    r.addr   = a;
    r.status = s;
    r.last   = 1'b0;
    if (step_out.size() < MAX_RESULTS) step_out.push_back(r);
  endfunction

  function automatic void step_pos();
    buf_pos = buf_pos + 16'd1;
  endfunction

  function automatic void end_check();
    if (remaining == 16'd0 || buf_pos >= buf_len) begin
      if (text_on) note_result(K_DATA, 8'h00, buf_pos, ST_OK);
      note_result(K_END, 8'h00, buf_pos, ST_OK);
      dec_phase = PH_SEP;
    end
  endfunction

  function automatic void open_field(logic [15:0] limit);
    remaining   = limit;
    field_start = buf_pos;
    hex_count   = 2'd0;
    dec_phase   = PH_IN;
    end_check();
  endfunction

  function automatic void decode_fault(status_t s);
    note_result(K_ERR, 8'h00, buf_pos, s);
    stuck = 1'b1;
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic valid, logic [15:0] limit);
    if (stuck) return;
    if (dec_phase == PH_FIRST) open_field(limit);
    if (!valid) return;
    if (buf_pos >= buf_len) begin
      decode_fault(ST_PAST_END);
      return;
    end
    if (dec_phase != PH_IN) begin
      if (b == CH_AMP) begin
        step_pos();
        open_field(limit);
      end else begin
        decode_fault(ST_MISSING_SEP);
      end
      return;
    end
    if (hex_count == 2'd1) begin
      hex_high  = hex_value(b);
      hex_count = 2'd2;
      step_pos();
      return;
    end
    if (hex_count == 2'd2) begin
      note_result(K_DATA, {hex_high, hex_value(b)}, buf_pos, ST_OK);
      hex_count = 2'd0;
    end else if (b == CH_AMP) begin
      if (text_on) note_result(K_DATA, 8'h00, buf_pos, ST_OK);
      note_result(K_END, 8'h00, buf_pos, ST_OK);
      step_pos();
      open_field(limit);
      return;
    end else if (b == CH_PCT) begin
      if ({16'd0, buf_pos} + 32'd3 > {16'd0, buf_len}) begin
        decode_fault(ST_SPLIT_ESCAPE);
      end else begin
        hex_count = 2'd1;
        step_pos();
      end
      return;
    end else begin
      note_result(K_DATA, b, buf_pos, ST_OK);
    end
    step_pos();
    remaining = remaining - 16'd1;
    end_check();
  endfunction

  function automatic void encode_fail();
    note_result(K_ERR, 8'h00, buf_pos, ST_NO_ROOM);
    buf_pos    = field_start;
    field_shut = 1'b1;
  endfunction

  function automatic void encode_put(logic [7:0] b);
    note_result(K_DATA, b, buf_pos, ST_OK);
    step_pos();
  endfunction

  function automatic bit room_for(int n);
    return {16'd0, buf_pos} + n < {16'd0, buf_len};
  endfunction

  function automatic void encode_byte(logic [7:0] b, logic valid, logic opens,
                                      logic [15:0] limit);
    if (opens) begin
      field_start = buf_pos;
      remaining   = limit;
      field_shut  = 1'b0;
      if (buf_pos > 16'd0) begin
        if (room_for(1)) begin
          encode_put(CH_AMP);
        end else begin
          encode_fail();
          return;
        end
      end
    end
    if (!valid || field_shut || remaining == 16'd0) return;
    if (text_on && b == 8'h00) begin
      field_shut = 1'b1;
      return;
    end
    if (b == CH_AMP || b == CH_PCT) begin
      if (room_for(3)) begin
        encode_put(CH_PCT);
        encode_put(CH_TWO);
        encode_put(b == CH_AMP ? CH_SIX : CH_FIVE);
      end else begin
        encode_fail();
        return;
      end
    end else if (room_for(1)) begin
      encode_put(b);
    end else begin
      encode_fail();
      return;
    end
    remaining = remaining - 16'd1;
  endfunction

  function automatic void codec_apply(item_t it);
    res_t r;
    step_out.delete();
    if (it.restart) clear_codec();
    if (it.func == FUNC_DECODE) begin
      decode_byte(it.data_byte, it.byte_valid, it.field_limit);
    end else begin
      encode_byte(it.data_byte, it.byte_valid, it.field_begin, it.field_limit);
    end
    for (int i = 0; i < step_out.size(); i++) begin
      r      = step_out[i];
      r.last = (i == step_out.size() - 1);
      result_fifo.push_back(r);
    end
  endfunction

  function automatic void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      error_count++;
      $display("[%0t] %s mismatch: expected %0h, actual %0h", $time, what, want, got);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: applies register writes and accepted items to the model, checks
  // each output transaction and watches for a stalled run.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    item_t taken;
    res_t  want;
    bit    moved;
    if (rst) begin
      buf_len = BUFFER_LENGTH_RESET;
      text_on = 1'b1;
      clear_codec();
      result_fifo.delete();
      idle_cycles = 0;
    end else begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        if (cfg_index == CFG_BUFFER_LENGTH) begin
          buf_len = cfg_data;
        end else if (cfg_index == CFG_TEXT_MODE) begin
          text_on = cfg_data[0];
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        if (result_fifo.size() == 0) begin
          error_count++;
          $display("[%0t] unexpected result: expected none, actual kind %0h data %h",
                   $time, m_axis_tuser, m_axis_tdata);
        end else begin
          want = result_fifo.pop_front();
          check_field("kind", want.kind, m_axis_tuser);
          check_field("byte", want.data, m_axis_tdata[7:0]);
          check_field("addr", want.addr, m_axis_tdata[23:8]);
          check_field("status", want.status, m_axis_tdata[26:24]);
          check_field("last", want.last, m_axis_tlast);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        moved             = 1'b1;
        taken.func        = s_axis_tuser[0];
        taken.data_byte   = s_axis_tdata[7:0];
        taken.byte_valid  = s_axis_tdata[8];
        taken.field_begin = s_axis_tdata[9];
        taken.field_limit = s_axis_tdata[25:10];
        taken.restart     = s_axis_tdata[26];
        codec_apply(taken);
      end
      if (moved) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("[%0t] no transaction for %0d cycles", $time, IDLE_LIMIT);
          $display("tb: FAIL");
          $finish;
        end
      end
    end
  end

  // Output side: a long hold-off when requested, otherwise changing stall patterns.
  always @(negedge clk) begin : receiver
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_pattern_t'($urandom_range(0, 3));
        mode_left = $urandom_range(8, 40);
      end
      mode_left--;
      case (rx_mode)
        RX_OPEN:   m_axis_tready <= 1'b1;
        RX_COIN:   m_axis_tready <= ($urandom_range(0, 1) == 0);
        RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default:   m_axis_tready <= (mode_left % 4 != 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic item_t make_item(logic func, logic [7:0] b, logic valid, logic opens,
                                      logic [15:0] limit, logic restart);
    item_t it;
    it.func        = func;
    it.data_byte   = b;
    it.byte_valid  = valid;
    it.field_begin = opens;
    it.field_limit = limit;
    it.restart     = restart;
    return it;
  endfunction

  function automatic logic [7:0] pick_hex_char();
    int n;
    n = $urandom_range(0, 21);
    if (n < 10) return 8'("0" + n);
    if (n < 16) return 8'("a" + n - 10);
    return 8'("A" + n - 16);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return CH_AMP;
      1:       return CH_PCT;
      2:       return 8'h00;
      3:       return pick_hex_char();
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [15:0] pick_limit();
    if ($urandom_range(0, 9) == 0) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(0, 6));
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, it.restart, it.field_limit, it.field_begin, it.byte_valid,
                      it.data_byte};
    s_axis_tuser  <= it.func;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (result_fifo.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic configure(logic [15:0] length, logic text);
    for (int n = 0; n < 2; n++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (n == 0) ? CFG_BUFFER_LENGTH : CFG_TEXT_MODE;
      cfg_data  <= (n == 0) ? length : {15'd0, text};
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic encode_record();
    int fields;
    int extra;
    fields = $urandom_range(1, 4);
    for (int f = 0; f < fields; f++) begin
      extra = $urandom_range(0, 5);
      send_item(make_item(FUNC_ENCODE, pick_byte(), $urandom_range(0, 4) != 0, 1'b1,
                          pick_limit(), f == 0 && $urandom_range(0, 2) == 0));
      repeat (extra) begin
        send_item(make_item(FUNC_ENCODE, pick_byte(), $urandom_range(0, 7) != 0, 1'b0,
                            pick_limit(), 1'b0));
      end
    end
  endtask

  // A well-formed packed buffer, now and then corrupted or cut short.
  task automatic decode_buffer();
    logic [7:0] stream[$];
    logic [7:0] c;
    int         fields;
    int         cut;
    fields = $urandom_range(1, 4);
    for (int f = 0; f < fields; f++) begin
      if (f > 0) stream.push_back(CH_AMP);
      repeat ($urandom_range(0, 5)) begin
        c = pick_byte();
        if (c == CH_AMP || c == CH_PCT) begin
          stream.push_back(CH_PCT);
          stream.push_back(CH_TWO);
          stream.push_back(c == CH_AMP ? CH_SIX : CH_FIVE);
        end else if ($urandom_range(0, 4) == 0) begin
          stream.push_back(CH_PCT);
          stream.push_back(pick_hex_char());
          stream.push_back(pick_hex_char());
        end else begin
          stream.push_back(c);
        end
      end
    end
    cut = stream.size();
    if (cut > 0 && $urandom_range(0, 4) == 0) begin
      stream[$urandom_range(0, cut - 1)] = 8'($urandom_range(0, 255));
    end
    if (cut > 0 && $urandom_range(0, 4) == 0) cut = $urandom_range(0, cut - 1);
    for (int i = 0; i < cut; i++) begin
      send_item(make_item(FUNC_DECODE, stream[i], $urandom_range(0, 9) != 0,
                          1'($urandom_range(0, 1)), pick_limit(),
                          i == 0 && $urandom_range(0, 4) != 0));
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_encode_escapes();
    send_item(make_item(FUNC_ENCODE, "x", 1'b1, 1'b0, 16'd5, 1'b1));
    send_item(make_item(FUNC_ENCODE, "a", 1'b1, 1'b1, 16'd3, 1'b0));
    send_item(make_item(FUNC_ENCODE, CH_AMP, 1'b1, 1'b0, 16'd3, 1'b0));
    send_item(make_item(FUNC_ENCODE, CH_PCT, 1'b1, 1'b0, 16'd3, 1'b0));
    send_item(make_item(FUNC_ENCODE, "z", 1'b1, 1'b0, 16'd3, 1'b0));
    send_item(make_item(FUNC_ENCODE, 8'hFF, 1'b0, 1'b1, 16'd0, 1'b0));
    send_item(make_item(FUNC_ENCODE, CH_AMP, 1'b1, 1'b1, 16'hFFFF, 1'b0));
    send_item(make_item(FUNC_ENCODE, 8'h00, 1'b1, 1'b0, 16'hFFFF, 1'b0));
    send_item(make_item(FUNC_ENCODE, "q", 1'b1, 1'b0, 16'hFFFF, 1'b0));
  endtask

  task automatic test_decode_fields();
    send_item(make_item(FUNC_DECODE, "h", 1'b1, 1'b0, 16'hFFFF, 1'b1));
    send_item(make_item(FUNC_DECODE, CH_PCT, 1'b1, 1'b0, 16'hFFFF, 1'b0));
    send_item(make_item(FUNC_DECODE, "z", 1'b1, 1'b0, 16'hFFFF, 1'b0));
    send_item(make_item(FUNC_DECODE, "f", 1'b1, 1'b0, 16'hFFFF, 1'b0));
    send_item(make_item(FUNC_DECODE, CH_AMP, 1'b1, 1'b0, 16'hFFFF, 1'b0));
    send_item(make_item(FUNC_DECODE, CH_AMP, 1'b1, 1'b0, 16'd2, 1'b0));
    send_item(make_item(FUNC_DECODE, "x", 1'b1, 1'b0, 16'd0, 1'b1));
    send_item(make_item(FUNC_DECODE, "y", 1'b1, 1'b0, 16'd4, 1'b0));
  endtask

  task automatic test_small_buffer();
    drain_results();
    configure(16'd4, 1'b0);
    send_item(make_item(FUNC_ENCODE, "a", 1'b1, 1'b1, 16'hFFFF, 1'b1));
    send_item(make_item(FUNC_ENCODE, "b", 1'b1, 1'b1, 16'hFFFF, 1'b0));
    send_item(make_item(FUNC_ENCODE, "c", 1'b1, 1'b1, 16'hFFFF, 1'b0));
    send_item(make_item(FUNC_DECODE, CH_PCT, 1'b1, 1'b0, 16'hFFFF, 1'b1));
    send_item(make_item(FUNC_DECODE, "4", 1'b1, 1'b0, 16'hFFFF, 1'b0));
    send_item(make_item(FUNC_DECODE, "1", 1'b1, 1'b0, 16'hFFFF, 1'b0));
    send_item(make_item(FUNC_DECODE, CH_AMP, 1'b1, 1'b0, 16'hFFFF, 1'b0));
    send_item(make_item(FUNC_DECODE, "x", 1'b1, 1'b0, 16'hFFFF, 1'b0));
    send_item(make_item(FUNC_DECODE, "a", 1'b1, 1'b0, 16'hFFFF, 1'b1));
    send_item(make_item(FUNC_DECODE, "b", 1'b1, 1'b0, 16'hFFFF, 1'b0));
    send_item(make_item(FUNC_DECODE, CH_PCT, 1'b1, 1'b0, 16'hFFFF, 1'b0));
  endtask

  task automatic test_backpressure();
    drain_results();
    configure(16'd1024, 1'b1);
    @(posedge clk);
    hold_request = 100;
    @(negedge clk);
    send_item(make_item(FUNC_ENCODE, CH_AMP, 1'b1, 1'b1, 16'hFFFF, 1'b1));
    repeat (23) send_item(make_item(FUNC_ENCODE, CH_AMP, 1'b1, 1'b1, 16'hFFFF, 1'b0));
    drain_results();
    encode_record();
  endtask

  task automatic test_random_traffic();
    logic [15:0] lengths[5];
    logic        texts[5];
    int          goal;
    lengths = '{16'd20, 16'd4, 16'd65535, 16'd9, 16'd1024};
    texts   = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
    for (int p = 0; p < 5; p++) begin
      drain_results();
      configure(lengths[p], texts[p]);
      goal = items_sent + 6;
      while (items_sent < goal) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3:    encode_record();
          4, 5, 6, 7, 8: decode_buffer();
          default: begin
            send_item(make_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                16'($urandom_range(0, 65535)),
                                $urandom_range(0, 5) == 0));
          end
        endcase
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_encode_escapes();
    test_decode_fields();
    test_small_buffer();
    test_backpressure();
    test_random_traffic();
    drain_results();
    if (error_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/afec_pkg.sv
sv/afec_core.sv
sv/afec_result_queue.sv
sv/ampersand_field_escape_codec.sv
tb/tb.sv
